### hdl/sliding_median_point_filter_assert.svh
// Assertion macros used by the checker file smpf_checker.sv.
`ifndef SLIDING_MEDIAN_POINT_FILTER_ASSERT_SVH
`define SLIDING_MEDIAN_POINT_FILTER_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define SMPF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define SMPF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/smpf_pkg.sv
package smpf_pkg;

  // Width of the window length register and of the bearing field.
  localparam int unsigned LenBits     = 5;
  localparam int unsigned BearingBits = 16;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SORT = 3'b010,
    ST_OUT  = 3'b100
  } state_e;

  // Control from the sequencer to every cell.
  typedef struct packed {
    logic load;   // Capture the window value from the history.
    logic step;   // Perform one odd-even transposition step.
    logic odd;    // Phase of the current step.
  } cell_ctrl_t;

endpackage

### hdl/sliding_median_point_filter.sv
// Sliding median point filter.
// Input channel: in_valid_i / in_stall_o carry pos_x, pos_y, bearing and
// scan_start; a transaction happens on a clock edge with valid high and
// stall low. Output channel: out_valid_o / out_stall_i carry the three
// medians. The window_length register is written through cfg_we_i.
// Each accepted point is written into a history of WINDOW_MAX entries.
// Once the window is full, the newest points are loaded into a row of
// WINDOW_MAX cells, which run WINDOW_MAX odd-even transposition steps,
// one per cycle, and the middle cell gives the result.
// The input is stalled while the row sorts a windowed point and until
// its result moves to the output register; a point that gives no result
// leaves the input free. The sorting row is the limit: it takes no new
// point before it is through with the last. A result waiting under
// out_stall_i does not block the input; a finished sort waits in the row,
// with the input stalled, until the output register is free.
// Reset empties the window and sets window_length to 7.
module sliding_median_point_filter #(
  parameter int unsigned WINDOW_MAX = 16,
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [smpf_pkg::LenBits-1:0]   cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [COORD_BITS-1:0]   pos_x_i,
  input  logic signed [COORD_BITS-1:0]   pos_y_i,
  input  logic [smpf_pkg::BearingBits-1:0] bearing_i,
  input  logic                           scan_start_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [COORD_BITS-1:0]   median_x_o,
  output logic signed [COORD_BITS-1:0]   median_y_o,
  output logic [smpf_pkg::BearingBits-1:0] median_bearing_o
);
  import smpf_pkg::*;

  localparam int unsigned F       = (COORD_BITS > BearingBits) ? COORD_BITS : BearingBits;
  localparam int unsigned KeyBits = 3 * F;
  localparam int unsigned SlotW   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int unsigned CntW    = $clog2(WINDOW_MAX + 1);
  localparam int unsigned StepW   = $clog2(WINDOW_MAX + 2);

  state_e state_q, state_d;
  logic [LenBits-1:0] wlen_q;
  logic [CntW-1:0]    fill_q;
  logic [SlotW-1:0]   slot_q;
  logic [StepW-1:0]   step_q;
  logic [CntW-1:0]    len_q;
  logic [KeyBits-1:0] hist_q [WINDOW_MAX];
  logic [KeyBits-1:0] cell_key [WINDOW_MAX];
  logic               cell_valid [WINDOW_MAX];
  logic [KeyBits-1:0] out_key_q;
  logic               out_valid_q;
  cell_ctrl_t         ctrl;
  logic               accept;
  logic               sort_done;
  logic               capture;
  logic [CntW-1:0]    fill_new;
  logic [SlotW-1:0]   slot_base;
  logic [CntW-1:0]    len_eff;
  logic [KeyBits-1:0] new_key;
  logic [4:0]         wlen_sat;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign slot_base  = scan_start_i ? '0 : slot_q;
  assign fill_new   = (scan_start_i ? CntW'(1) :
                       ((fill_q < CntW'(WINDOW_MAX)) ? fill_q + CntW'(1) : fill_q));

  // The sort is complete once every step has been registered; the result moves
  // to the output register as soon as that register is free.
  assign sort_done = (state_q == ST_SORT) && (step_q == StepW'(WINDOW_MAX + 1));
  assign capture   = (sort_done || state_q == ST_OUT) && (!out_valid_q || !out_stall_i);

  // Clamp the window length into 1..WINDOW_MAX.
  always_comb begin
    wlen_sat = wlen_q;
    if (wlen_q == '0) begin
      len_eff = CntW'(1);
    end else if (32'(wlen_sat) > WINDOW_MAX) begin
      len_eff = CntW'(WINDOW_MAX);
    end else begin
      len_eff = CntW'(wlen_sat);
    end
  end

  // Store keys with the coordinate sign flipped so unsigned compares order them.
  assign new_key = {F'({~pos_x_i[COORD_BITS-1], pos_x_i[COORD_BITS-2:0]}),
                    F'({~pos_y_i[COORD_BITS-1], pos_y_i[COORD_BITS-2:0]}),
                    F'(bearing_i)};

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hist_q[slot_base] <= new_key;
    end
  end

  // Sequencer: idle, sorting steps, finished sort waiting for the output register.
  always_comb begin
    state_d = state_q;
    ctrl    = '0;
    ctrl.odd = step_q[0];
    unique case (state_q)
      ST_IDLE: begin
        if (accept && fill_new >= len_eff) begin
          state_d = ST_SORT;
        end
      end
      ST_SORT: begin
        if (step_q == '0) begin
          ctrl.load = 1'b1;
        end else if (!sort_done) begin
          ctrl.step = 1'b1;
        end else if (capture) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (capture) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wlen_q      <= LenBits'(7);
      fill_q      <= '0;
      slot_q      <= '0;
      step_q      <= '0;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        wlen_q <= cfg_wdata_i;
      end
      if (accept) begin
        fill_q <= fill_new;
        slot_q <= (slot_base == SlotW'(WINDOW_MAX - 1)) ? '0 : slot_base + SlotW'(1);
        len_q  <= len_eff;
        step_q <= '0;
      end else if (state_q == ST_SORT && !sort_done) begin
        step_q <= step_q + StepW'(1);
      end
      if (capture) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Row of sorting cells; cell k loads the k-th newest point if k < len.
  for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_cell
    logic [SlotW-1:0]   src;
    logic [SlotW:0]     src_sum;
    logic [KeyBits-1:0] lk, rk;
    logic               lo, lv, rv;
    // Slot of the k-th newest point, wrapped into the history.
    assign src_sum = (SlotW+1)'(slot_q) + (SlotW+1)'(WINDOW_MAX - 1 - k);
    assign src     = (src_sum >= (SlotW+1)'(WINDOW_MAX)) ?
                     SlotW'(src_sum - (SlotW+1)'(WINDOW_MAX)) : SlotW'(src_sum);
    if (k == 0) begin : g_l
      assign lk = '0; assign lo = 1'b0; assign lv = 1'b0;
    end else begin : g_l
      assign lk = cell_key[k-1];
      assign lv = cell_valid[k-1];
      assign lo = (ctrl.odd != (((k - 1) % 2) == 0));
    end
    if (k == WINDOW_MAX - 1) begin : g_r
      assign rk = '0; assign rv = 1'b0;
    end else begin : g_r
      assign rk = cell_key[k+1];
      assign rv = cell_valid[k+1];
    end
    smpf_cell #(.KeyBits(KeyBits), .IsEven((k % 2) == 0)) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .load_key_i   (hist_q[src]),
      .load_valid_i (CntW'(k) < len_q),
      .left_key_i   (lk),
      .left_own_i   (lo),
      .left_valid_i (lv),
      .right_key_i  (rk),
      .right_valid_i(rv),
      .key_o        (cell_key[k]),
      .valid_o      (cell_valid[k])
    );
  end

  // Capture the middle cell once the last step has been registered.
  always_ff @(posedge clk_i) begin
    if (capture) begin
      out_key_q <= cell_key[len_q[CntW-1:1]];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign median_x_o       = {~out_key_q[2*F+COORD_BITS-1], out_key_q[2*F +: COORD_BITS-1]};
  assign median_y_o       = {~out_key_q[F+COORD_BITS-1], out_key_q[F +: COORD_BITS-1]};
  assign median_bearing_o = out_key_q[BearingBits-1:0];
endmodule

### hdl/smpf_cell.sv
// One cell of the sorting row: holds one key per field and exchanges with
// its right neighbor during the phase in which it owns the pair.
module smpf_cell #(
  parameter int unsigned KeyBits = 48,
  parameter bit          IsEven  = 1'b1
) (
  input  logic                  clk_i,
  input  smpf_pkg::cell_ctrl_t  ctrl_i,
  input  logic [KeyBits-1:0]    load_key_i,
  input  logic                  load_valid_i,
  input  logic [KeyBits-1:0]    left_key_i,
  input  logic                  left_own_i,
  input  logic                  left_valid_i,
  input  logic [KeyBits-1:0]    right_key_i,
  input  logic                  right_valid_i,
  output logic [KeyBits-1:0]    key_o,
  output logic                  valid_o
);
  import smpf_pkg::*;

  localparam int unsigned F = KeyBits / 3;

  logic [KeyBits-1:0] key_q, key_d;
  logic               valid_q;
  logic               own;

  // A cell owns the pair with its right neighbor when its parity matches.
  assign own = (ctrl_i.odd != IsEven);

  // Each field is sorted on its own: low keeps min, high keeps max.
  always_comb begin
    key_d = key_q;
    if (ctrl_i.load) begin
      key_d = load_key_i;
    end else if (ctrl_i.step) begin
      for (int f = 0; f < 3; f++) begin
        if (own && valid_q && right_valid_i) begin
          if (right_key_i[f*F +: F] < key_q[f*F +: F]) begin
            key_d[f*F +: F] = right_key_i[f*F +: F];
          end
        end else if (left_own_i && valid_q && left_valid_i) begin
          if (left_key_i[f*F +: F] > key_q[f*F +: F]) begin
            key_d[f*F +: F] = left_key_i[f*F +: F];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    if (ctrl_i.load) begin
      valid_q <= load_valid_i;
    end
  end

  assign key_o   = key_q;
  assign valid_o = valid_q;
endmodule

### hdl/smpf_checker.sv
module smpf_checker #(
  parameter int unsigned COORD_BITS = 16
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_stall_o,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic [COORD_BITS-1:0]  median_x_o
);
  `include "sliding_median_point_filter_assert.svh"

  // A stalled result is held with its value.
  `SMPF_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(median_x_o), "result dropped under stall")
  // Handshake controls are never unknown outside reset.
  `SMPF_ASSERT(a_known_ctrl, !$isunknown(out_valid_o) && !$isunknown(in_stall_o), "unknown handshake control")
  // A new result only appears right after the sorting row was busy.
  `SMPF_ASSERT(a_rise_after_busy, !$rose(out_valid_o) || $past(in_stall_o), "result appeared without a sort")
endmodule

bind sliding_median_point_filter smpf_checker #(.COORD_BITS(COORD_BITS)) u_smpf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .median_x_o  (median_x_o)
);

### tb/testbench.sv
module testbench;

  localparam int unsigned WinMax     = 16;
  localparam int unsigned CoordBits  = 16;
  localparam int unsigned NumRandom  = 1250;
  localparam int unsigned CycleLimit = 400000;

  // One set of medians as seen on the output channel.
  typedef struct packed {
    logic signed [CoordBits-1:0]          mx;
    logic signed [CoordBits-1:0]          my;
    logic [smpf_pkg::BearingBits-1:0]     mb;
  } medians_t;

  // Scoreboard: tracks the point window and the queue of expected medians.
  class median_scoreboard;
    logic signed [CoordBits-1:0]      x_win[WinMax];
    logic signed [CoordBits-1:0]      y_win[WinMax];
    logic [smpf_pkg::BearingBits-1:0] b_win[WinMax];
    int unsigned                      held;
    int unsigned                      next_slot;
    logic [smpf_pkg::LenBits-1:0]     win_len;
    medians_t                         pending[$];
    int unsigned                      mismatches;

    function void clear();
      held = 0;
      next_slot = 0;
      win_len = 5'd7;
      pending.delete();
      mismatches = 0;
    endfunction

    // Sorts the newest n values (as 17-bit keys) and picks the middle.
    function automatic logic [CoordBits:0] pick_middle(logic [CoordBits:0] keys[WinMax],
                                                         int unsigned n);
      logic [CoordBits:0] t;
      for (int i = 1; i < n; i++) begin
        for (int j = i; j > 0 && keys[j-1] > keys[j]; j--) begin
          t = keys[j];
          keys[j] = keys[j-1];
          keys[j-1] = t;
        end
      end
      return keys[n/2];
    endfunction

    // Notes an accepted point and predicts its medians, if any.
    function void note_point(logic signed [CoordBits-1:0] px, logic signed [CoordBits-1:0] py,
                             logic [smpf_pkg::BearingBits-1:0] pb, logic start);
      int unsigned n;
      int unsigned s;
      logic [CoordBits:0] kx[WinMax];
      logic [CoordBits:0] ky[WinMax];
      logic [CoordBits:0] kb[WinMax];
      medians_t m;
      if (start) begin
        held = 0;
        next_slot = 0;
      end
      x_win[next_slot] = px;
      y_win[next_slot] = py;
      b_win[next_slot] = pb;
      next_slot = (next_slot + 1) % WinMax;
      if (held < WinMax) held++;
      n = (win_len == 0) ? 1 : ((win_len > WinMax) ? WinMax : win_len);
      if (held < n) return;
      for (int k = 0; k < WinMax; k++) begin
        kx[k] = '0;
        ky[k] = '0;
        kb[k] = '0;
      end
      for (int k = 0; k < n; k++) begin
        s = (next_slot + WinMax - 1 - k) % WinMax;
        // Offset by the sign so an unsigned compare orders signed values.
        kx[k] = {1'b0, ~x_win[s][CoordBits-1], x_win[s][CoordBits-2:0]};
        ky[k] = {1'b0, ~y_win[s][CoordBits-1], y_win[s][CoordBits-2:0]};
        kb[k] = {1'b0, b_win[s]};
      end
      kx[0] = pick_middle(kx, n);
      ky[0] = pick_middle(ky, n);
      kb[0] = pick_middle(kb, n);
      m.mx = {~kx[0][CoordBits-1], kx[0][CoordBits-2:0]};
      m.my = {~ky[0][CoordBits-1], ky[0][CoordBits-2:0]};
      m.mb = kb[0][smpf_pkg::BearingBits-1:0];
      pending.insert(pending.size(), m);
    endfunction

    // Compares one output transaction with the oldest expectation.
    function void check_result(medians_t got);
      medians_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result x=%0d y=%0d b=%0d",
                                       got.mx, got.my, got.mb);
        return;
      end
      want = pending.pop_front();
      if (got.mx !== want.mx || got.my !== want.my || got.mb !== want.mb) begin
        mismatches++;
        if (mismatches <= 10)
          $display("median mismatch: expected x=%0d y=%0d b=%0d, got x=%0d y=%0d b=%0d",
                   want.mx, want.my, want.mb, got.mx, got.my, got.mb);
      end
    endfunction
  endclass

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              cfg_we_i = 1'b0;
  logic [smpf_pkg::LenBits-1:0]      cfg_wdata_i = '0;
  logic                              in_valid_i = 1'b0;
  logic                              in_stall_o;
  logic signed [CoordBits-1:0]       pos_x_i = '0;
  logic signed [CoordBits-1:0]       pos_y_i = '0;
  logic [smpf_pkg::BearingBits-1:0]  bearing_i = '0;
  logic                              scan_start_i = 1'b0;
  logic                              out_valid_o;
  logic                              out_stall_i = 1'b0;
  logic signed [CoordBits-1:0]       median_x_o;
  logic signed [CoordBits-1:0]       median_y_o;
  logic [smpf_pkg::BearingBits-1:0]  median_bearing_o;

  median_scoreboard board;
  int unsigned      cycles = 0;
  bit               idle_free = 1'b0;

  sliding_median_point_filter #(
    .WINDOW_MAX(WinMax),
    .COORD_BITS(CoordBits)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .pos_x_i(pos_x_i),
    .pos_y_i(pos_y_i),
    .bearing_i(bearing_i),
    .scan_start_i(scan_start_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .median_x_o(median_x_o),
    .median_y_o(median_y_o),
    .median_bearing_o(median_bearing_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Samples output transactions at the rising edge and guards the run time.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && out_valid_o && !out_stall_i)
      board.check_result({median_x_o, median_y_o, median_bearing_o});
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver stalls at random, except during the quiet stretch.
  always @(negedge clk_i) begin
    out_stall_i <= !idle_free && ($urandom_range(0, 99) < 25);
  end

  // Drives one point and waits for its transaction; valid stays high afterwards
  // until the next idle cycle or drain drops it.
  task automatic send_point(logic signed [CoordBits-1:0] px, logic signed [CoordBits-1:0] py,
                            logic [smpf_pkg::BearingBits-1:0] pb, logic start);
    while (!idle_free && $urandom_range(0, 99) < 25) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    pos_x_i <= px;
    pos_y_i <= py;
    bearing_i <= pb;
    scan_start_i <= start;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_point(px, py, pb, start);
    @(negedge clk_i);
  endtask

  // Waits until every expected result has come, plus the block latency.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (WinMax + 8) @(negedge clk_i);
  endtask

  task automatic set_window(logic [smpf_pkg::LenBits-1:0] len);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= len;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    board.win_len = len;
  endtask

  // Random point: mostly plain values, sometimes extremes or out-of-range bearings.
  task automatic random_point(logic start);
    logic signed [CoordBits-1:0]      px;
    logic signed [CoordBits-1:0]      py;
    logic [smpf_pkg::BearingBits-1:0] pb;
    px = CoordBits'($urandom());
    py = ($urandom_range(0, 9) == 0) ? 16'sh8000 : CoordBits'($urandom());
    pb = ($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 35999));
    if ($urandom_range(0, 3) == 0) px = CoordBits'($urandom_range(0, 7) - 4);
    send_point(px, py, pb, start);
  endtask

  initial begin
    logic [smpf_pkg::LenBits-1:0] lens[8];
    board = new();
    board.clear();
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: reset length, field extremes, scan restarts.
    send_point(16'sh7fff, 16'sh8000, 16'd0, 1'b1);
    send_point(16'sh8000, 16'sh7fff, 16'd35999, 1'b0);
    send_point(16'sh0000, 16'shffff, 16'hffff, 1'b0);
    send_point(16'sh0001, 16'sh0001, 16'd36000, 1'b0);
    send_point(16'shffff, 16'sh0000, 16'd18000, 1'b0);
    send_point(16'sh5555, 16'shaaaa, 16'h5555, 1'b0);
    send_point(16'shaaaa, 16'sh5555, 16'haaaa, 1'b0);
    send_point(16'sh1234, 16'sh4321, 16'd100, 1'b0);
    send_point(16'sh0, 16'sh0, 16'd1, 1'b1);
    // Length zero acts as one; above the maximum saturates.
    set_window(5'd0);
    send_point(16'sh8000, 16'sh7fff, 16'hffff, 1'b0);
    send_point(16'sh7fff, 16'sh8000, 16'h0000, 1'b1);
    set_window(5'd31);
    for (int i = 0; i < 17; i++) random_point(i == 0);
    // Shrinking the length mid-scan applies at once.
    set_window(5'd2);
    random_point(1'b0);

    lens = '{5'd1, 5'd16, 5'd3, 5'd4, 5'd8, 5'd17, 5'd7, 5'd5};
    for (int p = 0; p < 8; p++) begin
      set_window(lens[p]);
      idle_free = (p == 3);
      for (int i = 0; i < NumRandom / 8; i++) begin
        random_point(($urandom_range(0, 39) == 0));
        // Sender waits for all results once in a while.
        if (i == 50) drain();
      end
    end
    idle_free = 1'b0;
    drain();
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
